[rtl/core/assert_macros.svh]
// assertion macros shared by the framer modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication within the same cycle, checked out of reset
`define ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// implication in the next cycle, checked out of reset
`define ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/cpsf_pkg.sv]
// types, constants and helper functions of the crc-32 packet symbol framer
`timescale 1ns / 1ps
`default_nettype none

package cpsf_pkg;

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;
  localparam int unsigned CNT_W    = 6;  // holds up to 40 symbols
  localparam int unsigned SHIFT_W  = 40; // data byte plus four crc bytes

  // symbol width codes
  typedef enum logic [1:0] {
    SYM_W1 = 2'd0,
    SYM_W2 = 2'd1,
    SYM_W4 = 2'd2,
    SYM_W8 = 2'd3
  } sym_wlog2_t;

  // one request handed from the framing stage to the serialiser
  typedef struct packed {
    logic [7:0]  data;
    logic [31:0] crc;     // inverted crc, meaningful when finish is set
    logic        finish;
    logic [1:0]  wlog2;
  } job_t;

  // reflected crc-32 over one byte
  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // mask of the low symbol bits
  function automatic logic [7:0] sym_mask(input logic [1:0] wl);
    logic [7:0] m;
    unique case (sym_wlog2_t'(wl))
      SYM_W1: m = 8'h01;
      SYM_W2: m = 8'h03;
      SYM_W4: m = 8'h0F;
      SYM_W8: m = 8'hFF;
      default: m = 8'h01;
    endcase
    return m;
  endfunction

  // number of symbols one request produces
  function automatic logic [CNT_W-1:0] sym_count(input logic [1:0] wl, input logic fin);
    logic [CNT_W-1:0] n;
    unique case (sym_wlog2_t'(wl))
      SYM_W1: n = fin ? 6'd40 : 6'd8;
      SYM_W2: n = fin ? 6'd20 : 6'd4;
      SYM_W4: n = fin ? 6'd10 : 6'd2;
      SYM_W8: n = fin ? 6'd5  : 6'd1;
      default: n = 6'd8;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

[rtl/core/cpsf_front.sv]
// framing stage: packet phase tracking and running crc, one byte a cycle while in_ready is high
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module cpsf_front import cpsf_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_data_byte,
  input  wire logic [1:0] sym_wlog2,
  input  wire logic       job_take,
  output logic            job_valid,
  output job_t            job
);

  logic        phase_r, phase_nxt;
  logic [7:0]  remain_r, remain_nxt;
  logic [31:0] crc_r, crc_nxt;
  logic        job_valid_r, job_valid_nxt;
  job_t        job_r, job_nxt;

  logic        in_acc;
  logic [31:0] crc_upd;
  logic [7:0]  remain_dec;
  logic        finish;

  // request register frees up when the serialiser takes it
  assign in_ready = !job_valid_r || job_take;
  assign in_acc   = in_valid && in_ready;

  // crc and frame bookkeeping for the incoming byte
  always_comb begin
    crc_upd    = crc_byte(crc_r, in_data_byte);
    remain_dec = remain_r - 8'd1;
    finish     = phase_r ? (remain_dec == 8'd0) : (in_data_byte == 8'd0);

    phase_nxt     = phase_r;
    remain_nxt    = remain_r;
    crc_nxt       = crc_r;
    job_valid_nxt = job_valid_r && !job_take;
    job_nxt       = job_r;

    if (in_acc) begin
      job_valid_nxt = 1'b1;
      job_nxt.data   = in_data_byte;
      job_nxt.crc    = ~crc_upd;
      job_nxt.finish = finish;
      job_nxt.wlog2  = sym_wlog2;
      if (finish) begin
        phase_nxt  = 1'b0;
        remain_nxt = 8'd0;
        crc_nxt    = CRC_INIT;
      end else begin
        phase_nxt  = 1'b1;
        remain_nxt = phase_r ? remain_dec : in_data_byte;
        crc_nxt    = crc_upd;
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= 1'b0;
      remain_r    <= 8'd0;
      crc_r       <= CRC_INIT;
      job_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      remain_r    <= remain_nxt;
      crc_r       <= crc_nxt;
      job_valid_r <= job_valid_nxt;
    end
  end

  // request payload
  always_ff @(posedge clk) begin
    job_r <= job_nxt;
  end

  assign job_valid = job_valid_r;
  assign job       = job_r;

  // checks
  `ASSERT_NXT(a_len_opens_packet, in_acc && !phase_r && (in_data_byte != 8'd0), phase_r,
              "nonzero length byte did not open a packet")
  `ASSERT_NXT(a_end_resets_crc, in_acc && finish, (crc_r == CRC_INIT) && !phase_r,
              "crc or phase not restored at packet end")

endmodule

`default_nettype wire

[rtl/core/cpsf_ser.sv]
// symbol serialiser: cuts each request into symbols, low bits first
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module cpsf_ser import cpsf_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       job_valid,
  input  job_t            job,
  output logic            job_take,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_symbol,
  output logic            out_run_end,
  output logic            out_packet_end
);

  logic                 valid_r, valid_nxt;
  logic [SHIFT_W-1:0]   shift_r, shift_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 fin_r, fin_nxt;
  logic [1:0]           wl_r, wl_nxt;

  logic                 last;
  logic                 adv;
  logic [SHIFT_W-1:0]   shifted;

  assign last     = (cnt_r == 6'd1);
  assign adv      = valid_r && out_ready;
  assign job_take = job_valid && (!valid_r || (adv && last));

  // shift by one symbol width
  always_comb begin
    unique case (sym_wlog2_t'(wl_r))
      SYM_W1: shifted = {1'b0, shift_r[SHIFT_W-1:1]};
      SYM_W2: shifted = {2'b0, shift_r[SHIFT_W-1:2]};
      SYM_W4: shifted = {4'b0, shift_r[SHIFT_W-1:4]};
      SYM_W8: shifted = {8'b0, shift_r[SHIFT_W-1:8]};
      default: shifted = shift_r;
    endcase
  end

  // load a new request or step through the current one
  always_comb begin
    valid_nxt = valid_r;
    shift_nxt = shift_r;
    cnt_nxt   = cnt_r;
    fin_nxt   = fin_r;
    wl_nxt    = wl_r;
    if (job_take) begin
      valid_nxt = 1'b1;
      shift_nxt = {job.crc, job.data};
      cnt_nxt   = sym_count(job.wlog2, job.finish);
      fin_nxt   = job.finish;
      wl_nxt    = job.wlog2;
    end else if (adv) begin
      if (last) begin
        valid_nxt = 1'b0;
      end else begin
        shift_nxt = shifted;
        cnt_nxt   = cnt_r - 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      cnt_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    shift_r <= shift_nxt;
    fin_r   <= fin_nxt;
    wl_r    <= wl_nxt;
  end

  // result outputs
  assign out_valid      = valid_r;
  assign out_symbol     = shift_r[7:0] & sym_mask(wl_r);
  assign out_run_end    = last;
  assign out_packet_end = last && fin_r;

  // checks
  `ASSERT_IMP(a_cnt_live, valid_r, cnt_r != 6'd0, "symbol count empty while valid")
  `ASSERT_IMP(a_pkt_end_run_end, valid_r && out_packet_end, out_run_end,
              "packet end without run end")
  `ASSERT_NXT(a_drain_idle, adv && last && !job_valid, !valid_r,
              "serialiser stayed busy after its last symbol")

endmodule

`default_nettype wire

[rtl/core/crc32_packet_symbol_framer_core.sv]
// top level of the crc-32 packet symbol framer
`timescale 1ns / 1ps
`default_nettype none

// Packet bytes enter one per request: the first byte of a packet is its payload
// length, and the length byte plus payload run through a reflected CRC-32 (init
// all ones, inverted at the end). Every byte leaves as 8, 4, 2 or 1 symbols of
// 1, 2, 4 or 8 bits, lowest bits first, set by cfg_wdata; the width is sampled
// when a byte is taken. On the last payload byte, or a zero length byte, the
// four CRC bytes follow low byte first, and out_packet_end marks the final
// symbol. The serialiser emits one symbol per cycle while out_ready is high; a
// byte yields 8 >> w symbols (w = width code), five times that when it closes a
// packet; the framing stage holds one byte ahead, so input is taken every cycle
// at 8-bit symbols while out_ready stays high and no packet closes, and once per
// symbol run otherwise. Each byte passes the request and shift registers.
module crc32_packet_symbol_framer_core import cpsf_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_data_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_symbol,
  output logic            out_run_end,
  output logic            out_packet_end,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_wdata
);

  logic [1:0] sym_wlog2_r;
  logic       job_valid;
  logic       job_take;
  job_t       job;

  // symbol width register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sym_wlog2_r <= SYM_W1;
    end else if (cfg_we) begin
      sym_wlog2_r <= cfg_wdata;
    end
  end

  // framing and crc stage
  cpsf_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .sym_wlog2    (sym_wlog2_r),
    .job_take     (job_take),
    .job_valid    (job_valid),
    .job          (job)
  );

  // symbol serialiser
  cpsf_ser u_ser (
    .clk            (clk),
    .rst_n          (rst_n),
    .job_valid      (job_valid),
    .job            (job),
    .job_take       (job_take),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_symbol     (out_symbol),
    .out_run_end    (out_run_end),
    .out_packet_end (out_packet_end)
  );

endmodule

`default_nettype wire

[tb/sv/tb_crc32_packet_symbol_framer_core.sv]
// testbench of the crc-32 packet symbol framer: directed table, random packets, symbol checks
`timescale 1ns / 1ps

module tb_crc32_packet_symbol_framer_core;
  import cpsf_pkg::*;

  localparam int unsigned RUN_ITEMS   = 320;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned SETTLE      = 6;   // request and shift register stages plus margin

  // one expected symbol
  typedef struct packed {
    logic [7:0] symbol;
    logic       run_end;
    logic       packet_end;
  } sym_exp_t;

  // one row of the directed table; typed rows carry the last symbol of their run
  typedef struct packed {
    sym_wlog2_t wl;
    logic [7:0] data;
    logic       typed;
    logic [7:0] t_sym;
    logic       t_pe;
  } dir_row_t;

  localparam int unsigned DIR_ROWS = 20;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_data_byte;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_symbol;
  logic       out_run_end;
  logic       out_packet_end;
  logic       cfg_we;
  logic [1:0] cfg_wdata;

  // framer state as the testbench sees it
  logic [31:0] crc_run;
  logic        in_payload;
  logic [7:0]  payload_left;
  sym_wlog2_t  width_now;

  sym_exp_t pending_syms[$];

  int unsigned cycles;
  int unsigned errors;
  int unsigned bytes_sent;
  int unsigned packets_closed;
  int unsigned symbols_seen;
  int unsigned width_writes;
  int unsigned hold_left;
  bit          calm_tx;
  bit          calm_rx;

  // zero length, mid-packet width changes, zero bytes at every width and 0xFF at 1 and 8 bits
  dir_row_t dir_rows [0:DIR_ROWS-1] = '{
    '{SYM_W1, 8'h00, 1'b1, 8'h01, 1'b1},
    '{SYM_W1, 8'h03, 1'b1, 8'h00, 1'b0},
    '{SYM_W1, 8'hFF, 1'b1, 8'h01, 1'b0},
    '{SYM_W8, 8'h00, 1'b1, 8'h00, 1'b0},
    '{SYM_W2, 8'h80, 1'b0, 8'h00, 1'b0},
    '{SYM_W8, 8'h00, 1'b1, 8'hD2, 1'b1},
    '{SYM_W4, 8'h02, 1'b1, 8'h00, 1'b0},
    '{SYM_W4, 8'h80, 1'b1, 8'h08, 1'b0},
    '{SYM_W4, 8'h7F, 1'b0, 8'h00, 1'b0},
    '{SYM_W2, 8'h01, 1'b1, 8'h00, 1'b0},
    '{SYM_W2, 8'hC3, 1'b0, 8'h00, 1'b0},
    '{SYM_W8, 8'h01, 1'b1, 8'h01, 1'b0},
    '{SYM_W8, 8'hFF, 1'b0, 8'h00, 1'b0},
    '{SYM_W2, 8'h00, 1'b1, 8'h03, 1'b1},
    '{SYM_W4, 8'h00, 1'b1, 8'h0D, 1'b1},
    '{SYM_W8, 8'h02, 1'b1, 8'h02, 1'b0},
    '{SYM_W8, 8'hAA, 1'b1, 8'hAA, 1'b0},
    '{SYM_W8, 8'h55, 1'b0, 8'h00, 1'b0},
    '{SYM_W1, 8'h01, 1'b1, 8'h00, 1'b0},
    '{SYM_W1, 8'h00, 1'b0, 8'h00, 1'b0}
  };

  crc32_packet_symbol_framer_core u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data_byte   (in_data_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_symbol     (out_symbol),
    .out_run_end    (out_run_end),
    .out_packet_end (out_packet_end),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $error("timeout after %0d cycles, %0d symbols outstanding", cycles, pending_syms.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // gap length: mostly none or short, now and then long
  function automatic int unsigned pick_gap(input bit calm);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 8);
    return $urandom_range(12, 30);
  endfunction

  // reflected crc-32, one data bit at a time
  function automatic logic [31:0] crc_step(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c;
    for (int k = 0; k < 8; k++) begin
      if (r[0] ^ b[k]) r = (r >> 1) ^ CRC_POLY;
      else             r = r >> 1;
    end
    return r;
  endfunction

  // advance the framing state by one byte and queue the symbols it yields
  task automatic frame_byte(input logic [7:0] b, input logic typed,
                            input logic [7:0] t_sym, input logic t_pe);
    logic [7:0]  run_bytes [5];
    logic [31:0] crc_fin;
    logic [7:0]  v;
    logic [7:0]  mask;
    int unsigned nb;
    int unsigned per;
    int unsigned w;
    bit          closes;
    sym_exp_t    e;
    crc_run      = crc_step(crc_run, b);
    run_bytes[0] = b;
    nb           = 1;
    closes       = 1'b0;
    if (!in_payload) begin
      if (b == 8'h00) closes = 1'b1;
      else begin
        in_payload   = 1'b1;
        payload_left = b;
      end
    end else begin
      payload_left = payload_left - 8'd1;
      if (payload_left == 8'h00) closes = 1'b1;
    end
    // closing byte: inverted crc follows, low byte first
    if (closes) begin
      crc_fin = ~crc_run;
      for (int i = 0; i < 4; i++) run_bytes[i+1] = crc_fin[8*i +: 8];
      nb           = 5;
      crc_run      = CRC_INIT;
      in_payload   = 1'b0;
      payload_left = 8'h00;
      packets_closed++;
    end
    w    = 1 << width_now;
    per  = 8 >> width_now;
    mask = 8'hFF >> (8 - w);
    for (int i = 0; i < nb; i++) begin
      v = run_bytes[i];
      for (int j = 0; j < per; j++) begin
        e.symbol     = v & mask;
        e.run_end    = (i == nb - 1) && (j == per - 1);
        e.packet_end = closes && e.run_end;
        if (typed && e.run_end) begin
          e.symbol     = t_sym;
          e.packet_end = t_pe;
        end
        pending_syms.push_back(e);
        v = v >> w;
      end
    end
  endtask

  // offer one byte, wait for the request to be taken, then predict
  task automatic push_byte(input logic [7:0] b, input logic typed,
                           input logic [7:0] t_sym, input logic t_pe);
    int unsigned gap;
    gap = pick_gap(calm_tx);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    do @(posedge clk); while (!in_ready);
    frame_byte(b, typed, t_sym, t_pe);
    bytes_sent++;
  endtask

  // drain every pending symbol, let the pipeline settle, then write the width
  task automatic set_width(input sym_wlog2_t wl);
    in_valid <= 1'b0;
    while (pending_syms.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= wl;
    @(posedge clk);
    cfg_we    <= 1'b0;
    width_now = wl;
    width_writes++;
  endtask

  // symbol sink: checks against the oldest expectation and stalls at random
  always @(posedge clk) begin : symbol_sink
    sym_exp_t e;
    if (rst_n && out_valid && out_ready) begin
      symbols_seen++;
      if (pending_syms.size() == 0) begin
        $error("symbol %h with nothing expected", out_symbol);
        errors++;
      end else begin
        e = pending_syms.pop_front();
        if (out_symbol !== e.symbol) begin
          $error("out_symbol: expected %h, got %h", e.symbol, out_symbol);
          errors++;
        end
        if (out_run_end !== e.run_end) begin
          $error("out_run_end: expected %b, got %b", e.run_end, out_run_end);
          errors++;
        end
        if (out_packet_end !== e.packet_end) begin
          $error("out_packet_end: expected %b, got %b", e.packet_end, out_packet_end);
          errors++;
        end
      end
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      hold_left = pick_gap(calm_rx);
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // stimulus
  initial begin : stimulus
    int unsigned pkt_no;
    int unsigned big_pkt;
    int unsigned len;
    int unsigned r;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data_byte   = 8'h00;
    cfg_we         = 1'b0;
    cfg_wdata      = SYM_W1;
    cycles         = 0;
    errors         = 0;
    bytes_sent     = 0;
    packets_closed = 0;
    symbols_seen   = 0;
    width_writes   = 0;
    hold_left      = 0;
    calm_tx        = 1'b0;
    calm_rx        = 1'b0;
    crc_run        = CRC_INIT;
    in_payload     = 1'b0;
    payload_left   = 8'h00;
    width_now      = SYM_W1;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed table
    for (int i = 0; i < DIR_ROWS; i++) begin
      if (dir_rows[i].wl != width_now) set_width(dir_rows[i].wl);
      push_byte(dir_rows[i].data, dir_rows[i].typed, dir_rows[i].t_sym, dir_rows[i].t_pe);
    end

    // random well-formed packets, one of them at the longest length
    pkt_no  = 0;
    big_pkt = $urandom_range(1, 4);
    while (bytes_sent < RUN_ITEMS) begin
      pkt_no++;
      calm_tx = ($urandom_range(0, 4) == 0);
      calm_rx = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 1) == 1) set_width(sym_wlog2_t'($urandom_range(0, 3)));
      r = $urandom_range(0, 99);
      if (pkt_no == big_pkt) len = 255;
      else if (r < 15)       len = 0;
      else if (r < 90)       len = $urandom_range(1, 12);
      else                   len = $urandom_range(13, 40);
      push_byte(8'(len), 1'b0, 8'h00, 1'b0);
      for (int k = 0; k < len; k++) begin
        // occasional width change between payload bytes
        if ($urandom_range(0, 99) < 3) set_width(sym_wlog2_t'($urandom_range(0, 3)));
        push_byte(8'($urandom_range(0, 255)), 1'b0, 8'h00, 1'b0);
      end
    end

    // drain and let any stray symbol show up
    in_valid <= 1'b0;
    while (pending_syms.size() != 0) @(posedge clk);
    repeat (4 * SETTLE) @(posedge clk);

    $display("covered %0d bytes in %0d closed packets, %0d symbols checked",
             bytes_sent, packets_closed, symbols_seen);
    $display("width register written %0d times, %0d errors", width_writes, errors);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/cpsf_pkg.sv
rtl/core/cpsf_front.sv
rtl/core/cpsf_ser.sv
rtl/core/crc32_packet_symbol_framer_core.sv
tb/sv/tb_crc32_packet_symbol_framer_core.sv
